// ===== sv/bounded_queue_with_keyed_removal_macros.svh =====
// Assertion macros for the keyed-removal queue. They use the clock i_clk
// and the active-low reset i_rst_n of the module that includes them.
`ifndef BOUNDED_QUEUE_WITH_KEYED_REMOVAL_MACROS_SVH
`define BOUNDED_QUEUE_WITH_KEYED_REMOVAL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BQKR_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BQKR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/bqkr_pkg.sv =====
package bqkr_pkg;

    // Fixed widths of the request and result fields.
    localparam int KEY_IN_W = 64;
    localparam int IDENT_W  = 40;
    localparam int CMD_W    = 2;
    localparam int IDX_W    = 3;
    localparam int STAT_W   = 2;
    localparam int OCC_W    = 4;
    localparam int CAP_W    = 4;

    // Defaults for the top-level parameters and the capacity register.
    localparam int DEPTH_DEF    = 8;
    localparam int KEY_BITS_DEF = 64;
    localparam logic [CAP_W-1:0] CAP_RESET = 4'd5;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_cmd CMD_APPEND = 2'd0;
    localparam t_cmd CMD_REMOVE = 2'd1;
    localparam t_cmd CMD_CLEAR  = 2'd2;
    localparam t_cmd CMD_READ   = 2'd3;

    localparam t_status STAT_OK        = 2'd0;
    localparam t_status STAT_FULL      = 2'd1;
    localparam t_status STAT_EMPTY     = 2'd2;
    localparam t_status STAT_NOT_FOUND = 2'd3;

endpackage

// ===== sv/bqkr_store.sv =====
module bqkr_store #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 104,
    parameter int AW    = 3
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    // Entry memory: one write and one registered read per cycle.
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/bounded_queue_with_keyed_removal.sv =====
// Ordered queue of up to min(capacity, DEPTH) entries, each a KEY_BITS-wide
// key with a 40-bit id, kept in one entry memory with a registered read.
// Every request gives exactly one result carrying the status and the
// occupancy after the request. Append and clear pass from accept through
// the finish state to a loaded result, and read also passes through the read
// state. Remove walks the memory from the head one entry per cycle to find
// the first matching key, then moves each later entry up one place, again one
// entry per cycle; the single read port of the entry memory sets that pace.
// A new request is accepted once the previous one has handed its result to
// the output register, even if that result has not been taken yet.
// The capacity register may be written only while the block is idle.
`include "bounded_queue_with_keyed_removal_macros.svh"

module bounded_queue_with_keyed_removal #(
    parameter int DEPTH    = bqkr_pkg::DEPTH_DEF,
    parameter int KEY_BITS = bqkr_pkg::KEY_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bqkr_pkg::CAP_W-1:0]     i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [bqkr_pkg::CMD_W-1:0]     i_command,
    input  logic [bqkr_pkg::KEY_IN_W-1:0]  i_key,
    input  logic [bqkr_pkg::IDENT_W-1:0]   i_ident,
    input  logic [bqkr_pkg::IDX_W-1:0]     i_index,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [bqkr_pkg::STAT_W-1:0]    o_status,
    output logic [bqkr_pkg::OCC_W-1:0]     o_occupancy,
    output logic                           o_read_valid,
    output logic [bqkr_pkg::KEY_IN_W-1:0]  o_read_key,
    output logic [bqkr_pkg::IDENT_W-1:0]   o_read_ident
);
    import bqkr_pkg::*;

    // Count width holds DEPTH itself; the address width only indexes entries.
    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW = KEY_BITS + IDENT_W;
    localparam int LW = CW + CAP_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_cur, n_cur;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [CAP_W-1:0]    r_cap;

    // Result staged until the output register is free.
    t_status             r_status, n_status;
    logic                r_rvalid, n_rvalid;
    logic [KEY_BITS-1:0] r_rkey, n_rkey;
    logic [IDENT_W-1:0]  r_rident, n_rident;

    // Output register.
    logic                r_out_valid;
    t_status             r_out_status;
    logic [CW-1:0]       r_out_count;
    logic                r_out_rvalid;
    logic [KEY_BITS-1:0] r_out_rkey;
    logic [IDENT_W-1:0]  r_out_rident;

    // Entry memory port.
    logic          w_we, w_re;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [EW-1:0] w_wdata, w_rdata;

    logic                w_in_acc;
    logic                w_out_free;
    logic [LW-1:0]       w_limit;
    logic                w_full;
    logic                w_idx_ok;
    logic [CW-1:0]       w_cur1;
    logic [CW:0]         w_cur2;
    logic [KEY_BITS-1:0] w_rd_key;
    logic [IDENT_W-1:0]  w_rd_ident;

    bqkr_store #(
        .DEPTH (DEPTH),
        .WIDTH (EW),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // The usable limit saturates at the memory depth.
    assign w_limit  = (LW'(r_cap) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(r_cap);
    assign w_full   = (LW'(r_count) >= w_limit);
    assign w_idx_ok = ((CW + IDX_W)'(i_index) < (CW + IDX_W)'(r_count));

    // r_cur is always below the count while it is in use, so w_cur1 fits.
    assign w_cur1 = r_cur + CW'(1);
    assign w_cur2 = (CW + 1)'(r_cur) + (CW + 1)'(2);

    assign w_rd_key   = w_rdata[EW-1:IDENT_W];
    assign w_rd_ident = w_rdata[IDENT_W-1:0];

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_cur    = r_cur;
        n_key    = r_key;
        n_status = r_status;
        n_rvalid = r_rvalid;
        n_rkey   = r_rkey;
        n_rident = r_rident;
        w_we     = 1'b0;
        w_waddr  = '0;
        w_wdata  = w_rdata;
        w_re     = 1'b0;
        w_raddr  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_key    = i_key[KEY_BITS-1:0];
                    n_status = STAT_OK;
                    n_rvalid = 1'b0;
                    n_rkey   = '0;
                    n_rident = '0;
                    n_cur    = '0;
                    n_state  = S_FIN;
                    unique case (i_command)
                        CMD_APPEND: begin
                            if (w_full) begin
                                n_status = STAT_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_count[AW-1:0];
                                w_wdata = {i_key[KEY_BITS-1:0], i_ident};
                                n_count = r_count + CW'(1);
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                // Fetch the head; the search compares it next cycle.
                                w_re    = 1'b1;
                                n_state = S_SEARCH;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        CMD_READ: begin
                            if (w_idx_ok) begin
                                w_re     = 1'b1;
                                w_raddr  = AW'(i_index);
                                n_rvalid = 1'b1;
                                n_state  = S_READ;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_rkey   = w_rd_key;
                n_rident = w_rd_ident;
                n_state  = S_FIN;
            end
            S_SEARCH: begin
                // Entry r_cur is in the read register; fetch the next one.
                w_re    = (w_cur1 < r_count);
                w_raddr = w_cur1[AW-1:0];
                if (w_rd_key == r_key) begin
                    if (w_cur1 == r_count) begin
                        n_count = r_count - CW'(1);
                        n_state = S_FIN;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end else if (w_cur1 == r_count) begin
                    n_status = STAT_NOT_FOUND;
                    n_state  = S_FIN;
                end else begin
                    n_cur = w_cur1;
                end
            end
            S_SHIFT: begin
                // Entry r_cur + 1 is in the read register; move it up one place.
                w_we    = 1'b1;
                w_waddr = r_cur[AW-1:0];
                w_wdata = w_rdata;
                w_re    = (w_cur2 < (CW + 1)'(r_count));
                w_raddr = w_cur2[AW-1:0];
                if (w_cur2 == (CW + 1)'(r_count)) begin
                    n_count = r_count - CW'(1);
                    n_state = S_FIN;
                end else begin
                    n_cur = w_cur1;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_cap   <= CAP_RESET;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_key    <= n_key;
        r_status <= n_status;
        r_rvalid <= n_rvalid;
        r_rkey   <= n_rkey;
        r_rident <= n_rident;
    end

    // The output register takes the staged result, freeing the sequencer, once it is empty or being read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FIN && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && w_out_free) begin
            r_out_status <= r_status;
            r_out_count  <= r_count;
            r_out_rvalid <= r_rvalid;
            r_out_rkey   <= r_rkey;
            r_out_rident <= r_rident;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_occupancy  = OCC_W'(r_out_count);
    assign o_read_valid = r_out_rvalid;
    assign o_read_key   = KEY_IN_W'(r_out_rkey);
    assign o_read_ident = r_out_rident;

    `BQKR_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(DEPTH), "occupancy above depth")
    `BQKR_ASSERT_NOW(a_shift_range, r_state == S_SHIFT, w_cur1 < r_count, "shift past the tail")
    `BQKR_ASSERT_NEXT(a_clear_empties, w_in_acc && i_command == CMD_CLEAR, r_count == '0, "clear left entries")
    `BQKR_ASSERT_NEXT(a_full_keeps, w_in_acc && i_command == CMD_APPEND && w_full, $stable(r_count) && r_status == STAT_FULL, "full append changed state")

endmodule
